### hw/rtl/timed_midi_record_parser_top_defines.svh
// ---------------------------------------------------------------------------
// Timed MIDI record parser: assertion macros
// Concurrent check wrappers, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef TIMED_MIDI_RECORD_PARSER_TOP_DEFINES_SVH
`define TIMED_MIDI_RECORD_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TMRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tmrp check failed");
// next-cycle implication
`define TMRP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tmrp check failed");
`else
`define TMRP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TMRP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/tmrp_pkg.sv
// ---------------------------------------------------------------------------
// Timed MIDI record parser package
// Codes, byte constants and the result word shared by the parser modules.
// ---------------------------------------------------------------------------
package tmrp_pkg;

	// input commands
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_STORED   = 2'd0;
	localparam logic [1:0] KIND_REPORT   = 2'd1;
	localparam logic [1:0] KIND_BAD_PAIR = 2'd2;
	localparam logic [1:0] KIND_END      = 2'd3;

	// end reasons
	localparam logic [2:0] END_NONE   = 3'd0;
	localparam logic [2:0] END_TRACK  = 3'd1;
	localparam logic [2:0] END_ALL    = 3'd2;
	localparam logic [2:0] END_BADSYS = 3'd3;
	localparam logic [2:0] END_USER   = 3'd4;
	localparam logic [2:0] END_FULL   = 3'd5;

	// interface byte values
	localparam logic [7:0] DATA_MAX         = 8'h7F;
	localparam logic [7:0] ONE_DATA_LO      = 8'hC0;
	localparam logic [7:0] ONE_DATA_HI      = 8'hDF;
	localparam logic [7:0] CH_STATUS_MAX    = 8'hEF;
	localparam logic [7:0] SYS_FIRST        = 8'hF0;
	localparam logic [7:0] SYS_REPORT_HI    = 8'hF7;
	localparam logic [7:0] OVF_BYTE         = 8'hF8;
	localparam logic [7:0] MEASURE_END_BYTE = 8'hF9;
	localparam logic [7:0] END_MARK_BYTE    = 8'hFC;
	localparam logic [7:0] CLK_TO_HOST_BYTE = 8'hFD;
	localparam logic [7:0] TERM_BYTE        = 8'hFE;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  byte_count;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [7:0]  byte3;
		logic [15:0] event_index;
		logic [2:0]  end_reason;
		logic        last;
	} result_t;

	// up to two results produced by one accepted word
	typedef struct packed {
		logic       push;
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} pair_t;

	function automatic result_t make_result(
		input logic [1:0]  kind,
		input logic [2:0]  cnt,
		input logic [7:0]  b0,
		input logic [7:0]  b1,
		input logic [7:0]  b2,
		input logic [7:0]  b3,
		input logic [15:0] idx,
		input logic [2:0]  reason
	);
		result_t r;
		r.kind        = kind;
		r.byte_count  = cnt;
		r.byte0       = b0;
		r.byte1       = b1;
		r.byte2       = b2;
		r.byte3       = b3;
		r.event_index = idx;
		r.end_reason  = reason;
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

### hw/rtl/tmrp_in_if.sv
// ---------------------------------------------------------------------------
// Timed MIDI record parser input channel
// Valid/ready channel carrying a command and a received interface byte.
// ---------------------------------------------------------------------------
interface tmrp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;

	modport source (output valid, output command, output data_byte, input ready);
	modport sink   (input valid, input command, input data_byte, output ready);
endinterface

### hw/rtl/tmrp_out_if.sv
// ---------------------------------------------------------------------------
// Timed MIDI record parser result channel
// Valid/ready channel carrying one parsed event or report per word.
// ---------------------------------------------------------------------------
interface tmrp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  byte_count;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic [15:0] event_index;
	logic [2:0]  end_reason;
	logic        last;

	modport source (
		output valid, output kind, output byte_count,
		output byte0, output byte1, output byte2, output byte3,
		output event_index, output end_reason, output last,
		input ready
	);
	modport sink (
		input valid, input kind, input byte_count,
		input byte0, input byte1, input byte2, input byte3,
		input event_index, input end_reason, input last,
		output ready
	);
endinterface

### hw/rtl/tmrp_core.sv
// ---------------------------------------------------------------------------
// Timed MIDI record parser core
// Input register, parser state and single-pass decode of one word.
// ---------------------------------------------------------------------------
module tmrp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      max_events,
	tmrp_in_if.sink          midi,
	input  logic             pair_ready,
	output tmrp_pkg::pair_t  pair
);
	import tmrp_pkg::*;

	typedef enum logic [1:0] {
		PH_FIRST,   // timing byte or system byte
		PH_TIMED,   // byte after timing
		PH_DATA1,
		PH_DATA2
	} phase_t;

	logic        s1_valid_q;
	logic [1:0]  cmd_s1;
	logic [7:0]  byte_s1;

	logic        recording_q, recording_d;
	phase_t      phase_q, phase_d;
	logic [1:0]  need_q, need_d;
	logic [7:0]  timing_q, timing_d;
	logic [7:0]  status_q, status_d;
	logic [7:0]  data_q, data_d;
	logic [7:0]  rstat_q, rstat_d;
	logic [15:0] count_q, count_d;

	logic        fire;
	logic        do_store;
	logic        track_end;
	logic        do_finish;
	logic [1:0]  n_res;
	logic [15:0] count_inc;
	result_t     first;
	result_t     second;

	assign fire       = s1_valid_q && pair_ready;
	assign midi.ready = !s1_valid_q || pair_ready;
	assign count_inc  = count_q + 16'd1;

	always_comb begin
		recording_d = recording_q;
		phase_d     = phase_q;
		need_d      = need_q;
		timing_d    = timing_q;
		status_d    = status_q;
		data_d      = data_q;
		rstat_d     = rstat_q;
		count_d     = count_q;
		do_store    = 1'b0;
		track_end   = 1'b0;
		do_finish   = 1'b0;
		n_res       = 2'd0;
		first       = '0;
		second      = '0;

		case (cmd_s1)
			CMD_START: begin
				recording_d = 1'b1;
				phase_d     = PH_FIRST;
				need_d      = 2'd0;
				timing_d    = '0;
				status_d    = '0;
				data_d      = '0;
				rstat_d     = '0;
				count_d     = '0;
			end
			CMD_STOP: begin
				if (recording_q) begin
					first     = make_result(KIND_END, 3'd1, TERM_BYTE, '0, '0, '0,
						count_q, END_USER);
					n_res     = 2'd1;
					do_finish = 1'b1;
				end
			end
			CMD_BYTE: begin
				if (recording_q) begin
					case (phase_q)
						PH_FIRST: begin
							if (byte_s1 < SYS_FIRST) begin
								timing_d = byte_s1;
								phase_d  = PH_TIMED;
							end else if (byte_s1 == OVF_BYTE) begin
								first    = make_result(KIND_STORED, 3'd1, byte_s1, '0, '0, '0,
									count_q, END_NONE);
								do_store = 1'b1;
							end else if (byte_s1 == END_MARK_BYTE) begin
								// all end: report, then terminator
								first     = make_result(KIND_REPORT, 3'd1, byte_s1, '0, '0, '0,
									'0, END_NONE);
								second    = make_result(KIND_END, 3'd1, TERM_BYTE, '0, '0, '0,
									count_q, END_ALL);
								n_res     = 2'd2;
								do_finish = 1'b1;
							end else if (byte_s1 <= SYS_REPORT_HI || byte_s1 == MEASURE_END_BYTE
									|| byte_s1 == CLK_TO_HOST_BYTE || byte_s1 == TERM_BYTE) begin
								first = make_result(KIND_REPORT, 3'd1, byte_s1, '0, '0, '0,
									'0, END_NONE);
								n_res = 2'd1;
							end else begin
								first     = make_result(KIND_END, 3'd1, TERM_BYTE, '0, '0, '0,
									count_q, END_BADSYS);
								n_res     = 2'd1;
								do_finish = 1'b1;
							end
						end
						PH_TIMED: begin
							if (byte_s1 <= DATA_MAX) begin
								status_d = rstat_q;
								if (rstat_q inside {[ONE_DATA_LO:ONE_DATA_HI]}) begin
									first    = make_result(KIND_STORED, 3'd3, timing_q, rstat_q,
										byte_s1, '0, count_q, END_NONE);
									do_store = 1'b1;
								end else begin
									data_d  = byte_s1;
									need_d  = 2'd2;
									phase_d = PH_DATA2;
								end
							end else if (byte_s1 <= CH_STATUS_MAX) begin
								rstat_d  = byte_s1;
								status_d = byte_s1;
								need_d   = (byte_s1 inside {[ONE_DATA_LO:ONE_DATA_HI]}) ?
									2'd1 : 2'd2;
								phase_d  = PH_DATA1;
							end else if (byte_s1 == MEASURE_END_BYTE
									|| byte_s1 == END_MARK_BYTE) begin
								first     = make_result(KIND_STORED, 3'd2, timing_q, byte_s1,
									'0, '0, count_q, END_NONE);
								do_store  = 1'b1;
								track_end = (byte_s1 == END_MARK_BYTE);
							end else begin
								first   = make_result(KIND_BAD_PAIR, 3'd2, timing_q, byte_s1,
									'0, '0, '0, END_NONE);
								n_res   = 2'd1;
								phase_d = PH_FIRST;
							end
						end
						PH_DATA1: begin
							if (need_q == 2'd1) begin
								first    = make_result(KIND_STORED, 3'd3, timing_q, status_q,
									byte_s1, '0, count_q, END_NONE);
								do_store = 1'b1;
							end else begin
								data_d  = byte_s1;
								phase_d = PH_DATA2;
							end
						end
						default: begin
							first    = make_result(KIND_STORED, 3'd4, timing_q, status_q,
								data_q, byte_s1, count_q, END_NONE);
							do_store = 1'b1;
						end
					endcase
				end
			end
			default: ;
		endcase

		if (do_store) begin
			count_d = count_inc;
			phase_d = PH_FIRST;
			need_d  = 2'd0;
			if (track_end) begin
				second    = make_result(KIND_END, 3'd1, TERM_BYTE, '0, '0, '0,
					count_inc, END_TRACK);
				n_res     = 2'd2;
				do_finish = 1'b1;
			end else if (count_inc >= max_events) begin
				second    = make_result(KIND_END, 3'd1, TERM_BYTE, '0, '0, '0,
					count_inc, END_FULL);
				n_res     = 2'd2;
				do_finish = 1'b1;
			end else begin
				n_res = 2'd1;
			end
		end

		if (do_finish) begin
			recording_d = 1'b0;
			phase_d     = PH_FIRST;
			need_d      = 2'd0;
		end

		if (n_res == 2'd1)
			first.last = 1'b1;
		else if (n_res == 2'd2)
			second.last = 1'b1;
	end

	assign pair.push   = fire && (n_res != 2'd0);
	assign pair.count  = n_res;
	assign pair.first  = first;
	assign pair.second = second;

	// control and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			recording_q <= 1'b0;
			phase_q     <= PH_FIRST;
			need_q      <= 2'd0;
			timing_q    <= '0;
			status_q    <= '0;
			data_q      <= '0;
			rstat_q     <= '0;
			count_q     <= '0;
		end else begin
			if (midi.ready)
				s1_valid_q <= midi.valid;
			if (fire) begin
				recording_q <= recording_d;
				phase_q     <= phase_d;
				need_q      <= need_d;
				timing_q    <= timing_d;
				status_q    <= status_d;
				data_q      <= data_d;
				rstat_q     <= rstat_d;
				count_q     <= count_d;
			end
		end
	end

	// input word payload
	always_ff @(posedge clk) begin
		if (midi.valid && midi.ready) begin
			cmd_s1  <= midi.command;
			byte_s1 <= midi.data_byte;
		end
	end

endmodule

### hw/rtl/tmrp_out.sv
// ---------------------------------------------------------------------------
// Timed MIDI record parser result stage
// Holds the results of one word and hands them out one per word.
// ---------------------------------------------------------------------------
module tmrp_out (
	input  logic             clk,
	input  logic             arst_n,
	input  tmrp_pkg::pair_t  pair,
	output logic             pair_ready,
	tmrp_out_if.source       result
);
	import tmrp_pkg::*;

	result_t    head_q;
	result_t    tail_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign result.valid = (cnt_q != 2'd0);
	assign pop          = result.valid && result.ready;
	assign pair_ready   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (pair.push) begin
			cnt_q <= pair.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pair.push) begin
			head_q <= pair.first;
			tail_q <= pair.second;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

	assign result.kind        = head_q.kind;
	assign result.byte_count  = head_q.byte_count;
	assign result.byte0       = head_q.byte0;
	assign result.byte1       = head_q.byte1;
	assign result.byte2       = head_q.byte2;
	assign result.byte3       = head_q.byte3;
	assign result.event_index = head_q.event_index;
	assign result.end_reason  = head_q.end_reason;
	assign result.last        = head_q.last;

endmodule

### hw/rtl/timed_midi_record_parser_top.sv
// ---------------------------------------------------------------------------
// Timed MIDI record parser
// Record-side parser for a timed MIDI interface byte stream.
// ---------------------------------------------------------------------------
// The block takes one word per clock on midi while it is ready: a command (byte, start, stop)
// and a received byte. While recording, each event arrives as a timing byte
// followed by a MIDI message that may use running status; complete events
// are output as stored events with their store slot, interface system bytes
// are reported, stored, or end the recording, and every end of recording
// yields a terminator word (0xFE) with the next free slot and the reason.
// A word enters an input register and is decoded from it into a result
// register. The input accepts one word per clock as long as result words are
// taken: a word that yields two results (store full, track end, all end)
// holds the result register until both are taken, and the input stalls
// behind it. Words that give no result take no room in the result register
// but wait behind it too. The store capacity register is written through
// cfg_write_en/cfg_data and resets to 65535; the user must write it only
// while idle, as the block itself does not enforce this.
`include "timed_midi_record_parser_top_defines.svh"

module timed_midi_record_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [15:0] cfg_data,
	tmrp_in_if.sink     midi,
	tmrp_out_if.source  result
);
	import tmrp_pkg::*;

	logic [15:0] max_events_q;
	logic        pair_ready;
	pair_t       pair;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_events_q <= 16'hFFFF;
		end else if (cfg_write_en) begin
			max_events_q <= cfg_data;
		end
	end

	// decode: input register, parser state, one pass per word
	tmrp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_events (max_events_q),
		.midi       (midi),
		.pair_ready (pair_ready),
		.pair       (pair)
	);

	// result register: serializes one or two results per word
	tmrp_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair),
		.pair_ready (pair_ready),
		.result     (result)
	);

	// a pushed pair always carries at least one result
	`TMRP_ASSERT_IMP(a_pair_count, clk, arst_n, pair.push, pair.count != 2'd0)
	// with two results, only the second is marked last
	`TMRP_ASSERT_IMP(a_pair_last, clk, arst_n, pair.push && pair.count == 2'd2, !pair.first.last && pair.second.last)
	// end of recording is the final word, with terminator and a reason
	`TMRP_ASSERT_IMP(a_end_word, clk, arst_n, result.valid && result.kind == KIND_END, result.last && result.end_reason != END_NONE && result.byte0 == TERM_BYTE)
	// a pushed pair is presented in the next cycle
	`TMRP_ASSERT_NXT(a_pair_shown, clk, arst_n, pair.push, result.valid && result.kind == $past(pair.first.kind))

endmodule
